FILE: rtl/pgd_pkg.sv
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared widths, register indexes and item types of the pixel to glyph
// downsampler.
// ----------------------------------------------------------------------------
package pgd_pkg;

   localparam int PIXEL_W     = 8;
   localparam int GLYPH_W     = 8;
   localparam int DIM_W       = 13;
   localparam int REM_W       = 14;
   localparam int GCOUNT_W    = 5;
   localparam int GIDX_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int TABLE_BYTES = CSR_DATA_W / GLYPH_W;

   localparam logic [DIM_W-1:0]    RESET_SRC_WIDTH   = 13'd640;
   localparam logic [DIM_W-1:0]    RESET_SRC_HEIGHT  = 13'd480;
   localparam logic [DIM_W-1:0]    RESET_DST_WIDTH   = 13'd120;
   localparam logic [DIM_W-1:0]    RESET_DST_HEIGHT  = 13'd45;
   localparam logic [GCOUNT_W-1:0] RESET_GLYPH_COUNT = 5'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH        = 3'd0,
      CSR_SRC_HEIGHT       = 3'd1,
      CSR_DST_WIDTH        = 3'd2,
      CSR_DST_HEIGHT       = 3'd3,
      CSR_GLYPH_COUNT      = 3'd4,
      CSR_INVERT           = 3'd5,
      CSR_GLYPH_TABLE_LOW  = 3'd6,
      CSR_GLYPH_TABLE_HIGH = 3'd7
   } csr_index_type;

   // glyph selection controls handed to the mapper
   typedef struct packed {
      logic [GCOUNT_W-1:0] count;
      logic                invert;
   } glyph_cfg_type;

   // sampled item waiting for glyph lookup
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               line_end;
      logic               frame_end;
      logic               size_error;
   } sample_type;

endpackage

FILE: rtl/pgd_channels.sv
// ----------------------------------------------------------------------------
// pgd_channels
// Valid/ready channels of the downsampler: pixel input, glyph output and
// register write port.
// ----------------------------------------------------------------------------
interface pgd_req_if;
   import pgd_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface pgd_rsp_if;
   import pgd_pkg::*;
   logic               valid;
   logic               ready;
   logic [GLYPH_W-1:0] glyph;
   logic               line_end;
   logic               frame_end;
   logic               size_error;

   modport source (output valid, output glyph, output line_end, output frame_end,
                   output size_error, input ready);
   modport sink (input valid, input glyph, input line_end, input frame_end,
                 input size_error, output ready);
endinterface

interface pgd_csr_if;
   import pgd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pgd_glyph_map.sv
// ----------------------------------------------------------------------------
// pgd_glyph_map
// Maps an intensity to a glyph code: round(v*(n-1)/255) in exact integer
// form, then a byte lookup in the glyph table.
// ----------------------------------------------------------------------------
module pgd_glyph_map #(
   parameter int MAX_GLYPHS = 16
) (
   input  logic [pgd_pkg::PIXEL_W-1:0] pixel,
   input  pgd_pkg::glyph_cfg_type      cfg,
   input  logic [pgd_pkg::GLYPH_W-1:0] glyph_bytes [MAX_GLYPHS],
   output logic [pgd_pkg::GLYPH_W-1:0] glyph
);
   import pgd_pkg::*;

   localparam int SEL_W   = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int NUM_W   = 13;
   localparam int STEP    = 510;
   localparam int ROUNDING = 255;

   logic [GCOUNT_W-1:0]      count_clamped;
   logic [GIDX_W-1:0]        count_m1;
   logic [PIXEL_W-1:0]       level;
   logic [PIXEL_W+GIDX_W-1:0] product;
   logic [NUM_W-1:0]         numerator;
   logic [GIDX_W-1:0]        index;
   logic [GIDX_W-1:0]        index_lim;

   always_comb begin
      priority if (cfg.count == '0) begin
         count_clamped = GCOUNT_W'(1);
      end else if (32'(cfg.count) > MAX_GLYPHS) begin
         count_clamped = GCOUNT_W'(MAX_GLYPHS);
      end else begin
         count_clamped = cfg.count;
      end
      count_m1  = GIDX_W'(count_clamped - GCOUNT_W'(1));
      level     = cfg.invert ? ~pixel : pixel;
      product   = {{GIDX_W{1'b0}}, level} * {{PIXEL_W{1'b0}}, count_m1};
      numerator = NUM_W'({product, 1'b0}) + NUM_W'(ROUNDING);

      // quotient by 510 from a row of independent threshold compares
      index = '0;
      for (int k = 1; k < (1 << GIDX_W); k++) begin
         if (numerator >= NUM_W'(STEP * k)) begin
            index = GIDX_W'(k);
         end
      end
      index_lim = (index > count_m1) ? count_m1 : index;
      glyph     = glyph_bytes[index_lim[SEL_W-1:0]];
   end

endmodule

FILE: rtl/pixel_to_glyph_downsampler_core.sv
// ----------------------------------------------------------------------------
// pixel_to_glyph_downsampler_core
// Nearest-neighbor downscaler from a grayscale pixel stream to glyph codes.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries source pixels in raster order; frame_start on a pixel
//   restarts the row and column counters before that pixel is sampled.
//   rsp_chan carries one glyph per selected pixel with line_end and
//   frame_end markers, or a size_error item when a configured size is zero or
//   too large or the destination is larger than the source (that pixel is dropped).
//   csr_chan writes the registers (index 0..7: source width and height,
//   destination width and height, glyph count, invert, glyph table low and
//   high); it is always ready and should be written while no item is pending.
// Timing:
//   one pixel is accepted every clock while req_chan.ready is high. A selected
//   pixel is registered by the sampler when it is accepted, then the glyph
//   lookup fills the output register that drives rsp_chan.
//   Reset loads the default sizes (640x480 to 120x45, ten glyphs, empty
//   table) and clears the counters and both pipeline stages.
//   When the receiver stalls, the output register holds its item and the
//   sample stage keeps taking pixels until it holds a selected pixel or a
//   size_error item; after that req_chan.ready drops.
// ----------------------------------------------------------------------------
module pixel_to_glyph_downsampler_core #(
   parameter int MAX_DIMENSION = 4096,
   parameter int MAX_GLYPHS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   pgd_req_if.sink    req_chan,
   pgd_rsp_if.source  rsp_chan,
   pgd_csr_if.sink    csr_chan
);
   import pgd_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]    src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [GCOUNT_W-1:0] glyph_count_ff;
   logic                invert_ff;
   logic [GLYPH_W-1:0]  glyph_bytes_ff [MAX_GLYPHS];

   // sampling state
   logic [DIM_W-1:0] src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [DIM_W-1:0] src_col_in, src_row_in, out_col_in, out_row_in;
   logic [REM_W-1:0] col_rem_ff, row_rem_ff, col_rem_in, row_rem_in;
   logic             row_sel_ff, row_sel_in;

   // pipeline
   logic          s1_valid_ff, s1_valid_in;
   sample_type    s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0] rsp_glyph_ff;
   logic          rsp_line_end_ff, rsp_frame_end_ff, rsp_size_error_ff;

   logic               req_accept, out_free, s1_advance, size_bad;
   logic [DIM_W-1:0]   sc, sr, oc, orow, oc_upd;
   logic [REM_W-1:0]   cr, rr, col_rem_upd, row_rem_upd;
   logic [REM_W-1:0]   two_sw, two_sh, two_dw, two_dh, src_w_ext, src_h_ext;
   logic [REM_W:0]     col_sum, row_sum;
   logic               rsel, row_sel_now, col_sel, line_end_now, frame_end_now;
   logic               row_end, frame_done;
   glyph_cfg_type      glyph_cfg;
   logic [GLYPH_W-1:0] mapped_glyph;

   function automatic logic dim_ok(input logic [DIM_W-1:0] d);
      return (d != '0) && (32'(d) <= MAX_DIMENSION);
   endfunction

   // ---------------- configuration ----------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= RESET_SRC_WIDTH;
         src_height_ff  <= RESET_SRC_HEIGHT;
         dst_width_ff   <= RESET_DST_WIDTH;
         dst_height_ff  <= RESET_DST_HEIGHT;
         glyph_count_ff <= RESET_GLYPH_COUNT;
         invert_ff      <= 1'b0;
         for (int i = 0; i < MAX_GLYPHS; i++) begin
            glyph_bytes_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_SRC_WIDTH:   src_width_ff   <= csr_chan.data[DIM_W-1:0];
            CSR_SRC_HEIGHT:  src_height_ff  <= csr_chan.data[DIM_W-1:0];
            CSR_DST_WIDTH:   dst_width_ff   <= csr_chan.data[DIM_W-1:0];
            CSR_DST_HEIGHT:  dst_height_ff  <= csr_chan.data[DIM_W-1:0];
            CSR_GLYPH_COUNT: glyph_count_ff <= csr_chan.data[GCOUNT_W-1:0];
            CSR_INVERT:      invert_ff      <= csr_chan.data[0];
            CSR_GLYPH_TABLE_LOW: begin
               for (int i = 0; i < MAX_GLYPHS; i++) begin
                  if (i < TABLE_BYTES) begin
                     glyph_bytes_ff[i] <= csr_chan.data[GLYPH_W*(i%TABLE_BYTES) +: GLYPH_W];
                  end
               end
            end
            CSR_GLYPH_TABLE_HIGH: begin
               for (int i = 0; i < MAX_GLYPHS; i++) begin
                  if (i >= TABLE_BYTES) begin
                     glyph_bytes_ff[i] <= csr_chan.data[GLYPH_W*(i%TABLE_BYTES) +: GLYPH_W];
                  end
               end
            end
         endcase
      end
   end

   // ---------------- handshakes ----------------
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // ---------------- sampler ----------------
   always_comb begin
      size_bad = !dim_ok(src_width_ff) || !dim_ok(src_height_ff) ||
                 !dim_ok(dst_width_ff) || !dim_ok(dst_height_ff) ||
                 (dst_width_ff > src_width_ff) || (dst_height_ff > src_height_ff);

      src_w_ext = REM_W'(src_width_ff);
      src_h_ext = REM_W'(src_height_ff);
      two_sw    = {src_width_ff, 1'b0};
      two_sh    = {src_height_ff, 1'b0};
      two_dw    = {dst_width_ff, 1'b0};
      two_dh    = {dst_height_ff, 1'b0};

      // frame_start acts as a restart before the pixel is taken
      sc   = req_chan.frame_start ? '0 : src_col_ff;
      sr   = req_chan.frame_start ? '0 : src_row_ff;
      oc   = req_chan.frame_start ? '0 : out_col_ff;
      orow = req_chan.frame_start ? '0 : out_row_ff;
      cr   = req_chan.frame_start ? src_w_ext : col_rem_ff;
      rr   = req_chan.frame_start ? src_h_ext : row_rem_ff;
      rsel = req_chan.frame_start ? 1'b0 : row_sel_ff;

      row_sel_now = (sc == '0) ? ((rr < two_dh) && (orow < dst_height_ff)) : rsel;
      col_sel     = row_sel_now && (cr < two_dw) && (oc < dst_width_ff);

      line_end_now  = ({1'b0, oc} + 14'd1) == {1'b0, dst_width_ff};
      frame_end_now = line_end_now && (({1'b0, orow} + 14'd1) == {1'b0, dst_height_ff});

      // remainders saturate at zero
      col_sum     = col_sel ? ({1'b0, cr} + {1'b0, two_sw}) : {1'b0, cr};
      col_rem_upd = (col_sum >= {1'b0, two_dw}) ? REM_W'(col_sum - {1'b0, two_dw}) : '0;
      row_sum     = row_sel_now ? ({1'b0, rr} + {1'b0, two_sh}) : {1'b0, rr};
      row_rem_upd = (row_sum >= {1'b0, two_dh}) ? REM_W'(row_sum - {1'b0, two_dh}) : '0;
      oc_upd      = col_sel ? oc + DIM_W'(1) : oc;

      row_end    = ({1'b0, sc} + 14'd1) >= {1'b0, src_width_ff};
      frame_done = ({1'b0, sr} + 14'd1) >= {1'b0, src_height_ff};

      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      col_rem_in = col_rem_ff;
      row_rem_in = row_rem_ff;
      row_sel_in = row_sel_ff;

      if (req_accept && !size_bad) begin
         priority if (row_end && frame_done) begin
            src_col_in = '0;
            src_row_in = '0;
            out_col_in = '0;
            out_row_in = '0;
            col_rem_in = src_w_ext;
            row_rem_in = src_h_ext;
            row_sel_in = 1'b0;
         end else if (row_end) begin
            src_col_in = '0;
            src_row_in = sr + DIM_W'(1);
            out_col_in = '0;
            out_row_in = row_sel_now ? orow + DIM_W'(1) : orow;
            col_rem_in = src_w_ext;
            row_rem_in = row_rem_upd;
            row_sel_in = row_sel_now;
         end else begin
            src_col_in = sc + DIM_W'(1);
            src_row_in = sr;
            out_col_in = oc_upd;
            out_row_in = orow;
            col_rem_in = col_rem_upd;
            row_rem_in = rr;
            row_sel_in = row_sel_now;
         end
      end

      s1_item_in.pixel      = req_chan.pixel;
      s1_item_in.line_end   = !size_bad && line_end_now;
      s1_item_in.frame_end  = !size_bad && frame_end_now;
      s1_item_in.size_error = size_bad;

      priority if (req_accept && (size_bad || col_sel)) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      priority if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         col_rem_ff   <= REM_W'(RESET_SRC_WIDTH);
         row_rem_ff   <= REM_W'(RESET_SRC_HEIGHT);
         row_sel_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         col_rem_ff   <= col_rem_in;
         row_rem_ff   <= row_rem_in;
         row_sel_ff   <= row_sel_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- glyph lookup and output register ----------------
   assign glyph_cfg.count  = glyph_count_ff;
   assign glyph_cfg.invert = invert_ff;

   pgd_glyph_map #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_glyph_map (
      .pixel       (s1_item_ff.pixel),
      .cfg         (glyph_cfg),
      .glyph_bytes (glyph_bytes_ff),
      .glyph       (mapped_glyph)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_advance) begin
         rsp_glyph_ff      <= s1_item_ff.size_error ? '0 : mapped_glyph;
         rsp_line_end_ff   <= s1_item_ff.line_end;
         rsp_frame_end_ff  <= s1_item_ff.frame_end;
         rsp_size_error_ff <= s1_item_ff.size_error;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.glyph      = rsp_glyph_ff;
   assign rsp_chan.line_end   = rsp_line_end_ff;
   assign rsp_chan.frame_end  = rsp_frame_end_ff;
   assign rsp_chan.size_error = rsp_size_error_ff;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel to glyph downsampler. A short table of
// directed items (sizes at their limits, glyph count clamping, invert, bad
// sizes) runs first, then random phases of raster streams under changing
// register settings. Every accepted pixel goes through a local model of the
// sampler and glyph lookup; each glyph item leaving the block is compared
// against the oldest predicted item.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pgd_pkg::*;

   localparam int          CLK_PERIOD    = 8;
   localparam int          RESET_CYCLES  = 6;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          RANDOM_ITEMS  = 1530;
   localparam int unsigned MAX_DIM       = 4096;
   localparam int unsigned MAX_CODES     = 16;
   localparam int unsigned CNT_MASK      = 32'h1FFF;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic               line_end;
      logic               frame_end;
      logic               size_error;
   } glyph_item_type;

   typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] reg_value;
      logic [PIXEL_W-1:0]    pixel;
      logic                  frame_start;
      logic                  typed;
      glyph_item_type        want;
   } table_row_type;

   localparam glyph_item_type SIZE_ERROR_ITEM = '{glyph: 8'h00, line_end: 1'b0,
                                                  frame_end: 1'b0, size_error: 1'b1};

   logic clock = 1'b0;
   logic reset;

   pgd_req_if req_bus ();
   pgd_rsp_if rsp_bus ();
   pgd_csr_if csr_bus ();

   pixel_to_glyph_downsampler_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // register copy
   int unsigned          cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h;
   int unsigned          cfg_glyph_count;
   bit                   cfg_invert;
   logic [63:0]          cfg_table_lo, cfg_table_hi;

   // sampler state
   int unsigned          src_col, src_row, out_col, out_row;
   int unsigned          col_rem, row_rem;
   bit                   row_hit;

   glyph_item_type       expected_glyphs[$];
   table_row_type        directed[$];
   int                   fail_count = 0;
   int                   idle_cycles = 0;
   bit                   pixels_in_flight = 0;
   bit                   no_gaps = 0;
   bit                   rsp_calm = 0;
   int                   rsp_stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic bit dim_ok(input int unsigned d);
      return d >= 1 && d <= MAX_DIM;
   endfunction

   function automatic logic [GLYPH_W-1:0] glyph_for(input logic [PIXEL_W-1:0] px);
      int unsigned n, v, idx;
      n = cfg_glyph_count;
      if (n < 1) n = 1;
      if (n > MAX_CODES) n = MAX_CODES;
      v = 32'(px);
      if (cfg_invert) v = 255 - v;
      idx = (n == 1) ? 0 : (2 * v * (n - 1) + 255) / 510;
      if (idx > n - 1) idx = n - 1;
      if (idx < 8) return cfg_table_lo[8*idx +: 8];
      return cfg_table_hi[8*(idx-8) +: 8];
   endfunction

   task automatic restart_frame();
      src_col = 0;
      src_row = 0;
      out_col = 0;
      out_row = 0;
      col_rem = cfg_src_w;
      row_rem = cfg_src_h;
      row_hit = 0;
   endtask

   task automatic reset_model();
      cfg_src_w       = 32'(RESET_SRC_WIDTH);
      cfg_src_h       = 32'(RESET_SRC_HEIGHT);
      cfg_dst_w       = 32'(RESET_DST_WIDTH);
      cfg_dst_h       = 32'(RESET_DST_HEIGHT);
      cfg_glyph_count = 32'(RESET_GLYPH_COUNT);
      cfg_invert      = 0;
      cfg_table_lo    = '0;
      cfg_table_hi    = '0;
      restart_frame();
   endtask

   // advances the sampler by one pixel, returns the glyph item it causes
   task automatic sample_pixel(input logic [PIXEL_W-1:0] px, input logic fs,
                               output bit made, output glyph_item_type res);
      bit col_hit, last_col;
      made = 0;
      res  = '0;
      if (!dim_ok(cfg_src_w) || !dim_ok(cfg_src_h) || !dim_ok(cfg_dst_w) ||
          !dim_ok(cfg_dst_h) || cfg_dst_w > cfg_src_w || cfg_dst_h > cfg_src_h) begin
         made = 1;
         res  = SIZE_ERROR_ITEM;
      end else begin
         if (fs) restart_frame();
         if (src_col == 0)
            row_hit = row_rem < 2 * cfg_dst_h && out_row < cfg_dst_h;
         col_hit = row_hit && col_rem < 2 * cfg_dst_w && out_col < cfg_dst_w;
         if (col_hit) begin
            last_col      = (out_col + 1 == cfg_dst_w);
            res.glyph     = glyph_for(px);
            res.line_end  = last_col;
            res.frame_end = last_col && (out_row + 1 == cfg_dst_h);
            made          = 1;
            out_col       = (out_col + 1) & CNT_MASK;
            col_rem       = col_rem + 2 * cfg_src_w;
         end
         // remainder saturates at zero after a size change within a frame
         col_rem = (col_rem >= 2 * cfg_dst_w) ? col_rem - 2 * cfg_dst_w : 0;
         if (src_col + 1 >= cfg_src_w) begin
            if (src_row + 1 >= cfg_src_h) begin
               restart_frame();
            end else begin
               if (row_hit) begin
                  row_rem = row_rem + 2 * cfg_src_h;
                  out_row = (out_row + 1) & CNT_MASK;
               end
               row_rem = (row_rem >= 2 * cfg_dst_h) ? row_rem - 2 * cfg_dst_h : 0;
               src_row = (src_row + 1) & CNT_MASK;
               src_col = 0;
               out_col = 0;
               col_rem = cfg_src_w;
            end
         end else begin
            src_col = (src_col + 1) & CNT_MASK;
         end
      end
   endtask

   // waits until every predicted glyph item has left the block
   task automatic settle();
      if (pixels_in_flight) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         while (expected_glyphs.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         pixels_in_flight = 0;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_SRC_WIDTH:        cfg_src_w       = 32'(value[DIM_W-1:0]);
         CSR_SRC_HEIGHT:       cfg_src_h       = 32'(value[DIM_W-1:0]);
         CSR_DST_WIDTH:        cfg_dst_w       = 32'(value[DIM_W-1:0]);
         CSR_DST_HEIGHT:       cfg_dst_h       = 32'(value[DIM_W-1:0]);
         CSR_GLYPH_COUNT:      cfg_glyph_count = 32'(value[GCOUNT_W-1:0]);
         CSR_INVERT:           cfg_invert      = value[0];
         CSR_GLYPH_TABLE_LOW:  cfg_table_lo    = value;
         CSR_GLYPH_TABLE_HIGH: cfg_table_hi    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // random bits above the field so the unused part of the word toggles
   function automatic logic [CSR_DATA_W-1:0] pad_value(input int unsigned v, input int w);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom, $urandom};
      word = (word >> w) << w;
      return word | (CSR_DATA_W'(v) & ((64'd1 << w) - 1));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs,
                             input bit typed, input glyph_item_type want);
      int             gap;
      bit             made;
      glyph_item_type res;
      gap = no_gaps ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= px;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pixels_in_flight = 1;
      sample_pixel(px, fs, made, res);
      if (typed) expected_glyphs.push_back(want);
      else if (made) expected_glyphs.push_back(res);
   endtask

   function automatic table_row_type reg_row(input csr_index_type idx,
                                             input logic [CSR_DATA_W-1:0] value);
      table_row_type row;
      row           = '0;
      row.kind      = ROW_REG;
      row.reg_idx   = idx;
      row.reg_value = value;
      return row;
   endfunction

   function automatic table_row_type pixel_row(input logic [PIXEL_W-1:0] px, input logic fs);
      table_row_type row;
      row             = '0;
      row.kind        = ROW_PIXEL;
      row.pixel       = px;
      row.frame_start = fs;
      return row;
   endfunction

   function automatic table_row_type pixel_want(input logic [PIXEL_W-1:0] px, input logic fs,
                                                input glyph_item_type want);
      table_row_type row;
      row       = pixel_row(px, fs);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   // with a 1x1 output every glyph closes its row and its frame
   function automatic glyph_item_type lone_glyph(input logic [GLYPH_W-1:0] g);
      return '{glyph: g, line_end: 1'b1, frame_end: 1'b1, size_error: 1'b0};
   endfunction

   // receiver side
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(99) < 20) rsp_stall_left = pick_gap();
      end
      if ($urandom_range(299) == 0) rsp_calm = !rsp_calm;
   end

   always @(posedge clock) begin
      glyph_item_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_glyphs.size() == 0) begin
            $error("glyph item with nothing expected: glyph %02h line_end %0b",
                   rsp_bus.glyph, rsp_bus.line_end);
            fail_count++;
         end else begin
            want = expected_glyphs.pop_front();
            if (rsp_bus.glyph !== want.glyph) begin
               $error("glyph: expected %02h, got %02h", want.glyph, rsp_bus.glyph);
               fail_count++;
            end
            if (rsp_bus.line_end !== want.line_end) begin
               $error("line_end: expected %0b, got %0b", want.line_end, rsp_bus.line_end);
               fail_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_bus.frame_end);
               fail_count++;
            end
            if (rsp_bus.size_error !== want.size_error) begin
               $error("size_error: expected %0b, got %0b", want.size_error,
                      rsp_bus.size_error);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          sent, items, frame_len, mode, r, k;
      int unsigned sw, sh, dw, dh, gc;
      logic        fs;
      logic [7:0]  px;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.pixel       = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_SRC_WIDTH;
      csr_bus.data        = '0;

      // reset sizes: first pixel of the frame is not sampled
      directed.push_back(pixel_row(8'd17, 1'b1));
      // table reads "0123456789ABCDEF"
      directed.push_back(reg_row(CSR_GLYPH_TABLE_LOW, 64'h3736353433323130));
      directed.push_back(reg_row(CSR_GLYPH_TABLE_HIGH, 64'h4645444342413938));
      directed.push_back(reg_row(CSR_SRC_WIDTH, 64'd1));
      directed.push_back(reg_row(CSR_SRC_HEIGHT, 64'd1));
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd1));
      directed.push_back(reg_row(CSR_DST_HEIGHT, 64'd1));
      directed.push_back(pixel_want(8'd0, 1'b1, lone_glyph(8'h30)));
      directed.push_back(pixel_want(8'd255, 1'b0, lone_glyph(8'h39)));
      directed.push_back(reg_row(CSR_GLYPH_COUNT, 64'd16));
      directed.push_back(pixel_want(8'd255, 1'b0, lone_glyph(8'h46)));
      directed.push_back(pixel_row(8'd128, 1'b0));
      directed.push_back(pixel_want(8'd0, 1'b1, lone_glyph(8'h30)));
      directed.push_back(reg_row(CSR_INVERT, 64'd1));
      directed.push_back(pixel_want(8'd0, 1'b0, lone_glyph(8'h46)));
      directed.push_back(pixel_want(8'd255, 1'b0, lone_glyph(8'h30)));
      // single glyph, and a zero count clamped up to one
      directed.push_back(reg_row(CSR_GLYPH_COUNT, 64'd1));
      directed.push_back(pixel_want(8'd200, 1'b0, lone_glyph(8'h30)));
      directed.push_back(reg_row(CSR_GLYPH_COUNT, 64'd0));
      directed.push_back(pixel_want(8'd77, 1'b0, lone_glyph(8'h30)));
      // count above the table clamps to sixteen
      directed.push_back(reg_row(CSR_GLYPH_COUNT, 64'd31));
      directed.push_back(pixel_want(8'd0, 1'b0, lone_glyph(8'h46)));
      directed.push_back(reg_row(CSR_INVERT, 64'd0));
      directed.push_back(pixel_row(8'd9, 1'b0));
      // bad sizes drop the pixel and ignore frame_start
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd0));
      directed.push_back(pixel_want(8'd90, 1'b1, SIZE_ERROR_ITEM));
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd2));
      directed.push_back(pixel_want(8'd91, 1'b0, SIZE_ERROR_ITEM));
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd1));
      directed.push_back(reg_row(CSR_SRC_WIDTH, 64'd8191));
      directed.push_back(pixel_want(8'd92, 1'b1, SIZE_ERROR_ITEM));
      directed.push_back(reg_row(CSR_SRC_WIDTH, 64'd4096));
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd4096));
      directed.push_back(reg_row(CSR_SRC_HEIGHT, 64'd0));
      directed.push_back(pixel_want(8'd93, 1'b0, SIZE_ERROR_ITEM));
      directed.push_back(reg_row(CSR_SRC_HEIGHT, 64'd1));
      directed.push_back(reg_row(CSR_DST_HEIGHT, 64'd4097));
      directed.push_back(pixel_want(8'd94, 1'b1, SIZE_ERROR_ITEM));
      // widest line, every pixel sampled
      directed.push_back(reg_row(CSR_DST_HEIGHT, 64'd1));
      directed.push_back(pixel_row(8'd255, 1'b1));
      directed.push_back(pixel_row(8'd1, 1'b0));
      directed.push_back(pixel_row(8'd254, 1'b0));
      // tallest column
      directed.push_back(reg_row(CSR_SRC_WIDTH, 64'd1));
      directed.push_back(reg_row(CSR_DST_WIDTH, 64'd1));
      directed.push_back(reg_row(CSR_SRC_HEIGHT, 64'd4096));
      directed.push_back(reg_row(CSR_DST_HEIGHT, 64'd4096));
      directed.push_back(pixel_row(8'd100, 1'b1));
      directed.push_back(pixel_row(8'd170, 1'b0));
      directed.push_back(pixel_row(8'd85, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      reset_model();

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_REG) begin
            settle();
            write_reg(directed[i].reg_idx, directed[i].reg_value);
         end else begin
            send_pixel(directed[i].pixel, directed[i].frame_start, directed[i].typed,
                       directed[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r  = $urandom_range(99);
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 10);
         dw = $urandom_range(1, sw);
         dh = $urandom_range(1, sh);
         frame_len = sw * sh;
         items = frame_len * $urandom_range(1, 3);
         if (items > 160) items = 160;
         if (r < 8) begin
            case ($urandom_range(4))
               0: dw = sw + $urandom_range(1, 4);
               1: dh = 0;
               2: dw = 0;
               3: sw = $urandom_range(MAX_DIM + 1, 8191);
               default: dh = sh + 1;
            endcase
            items = $urandom_range(3, 8);
         end else if (r < 18) begin
            if ($urandom_range(1)) begin
               sw = $urandom_range(MAX_DIM - 6, MAX_DIM);
               sh = $urandom_range(1, 3);
            end else begin
               sw = $urandom_range(1, 3);
               sh = $urandom_range(MAX_DIM - 6, MAX_DIM);
            end
            dw = $urandom_range(1) ? sw : $urandom_range(1, sw);
            dh = $urandom_range(1) ? sh : $urandom_range(1, sh);
            frame_len = sw * sh;
            items = $urandom_range(40, 150);
         end

         settle();
         write_reg(CSR_SRC_WIDTH, pad_value(sw, DIM_W));
         write_reg(CSR_SRC_HEIGHT, pad_value(sh, DIM_W));
         write_reg(CSR_DST_WIDTH, pad_value(dw, DIM_W));
         write_reg(CSR_DST_HEIGHT, pad_value(dh, DIM_W));
         if ($urandom_range(3) != 0) begin
            if ($urandom_range(9) == 0) gc = $urandom_range(1) ? 0 : $urandom_range(17, 31);
            else gc = $urandom_range(1, MAX_CODES);
            write_reg(CSR_GLYPH_COUNT, pad_value(gc, GCOUNT_W));
         end
         if ($urandom_range(1)) write_reg(CSR_INVERT, pad_value($urandom_range(1), 1));
         if ($urandom_range(2) == 0) write_reg(CSR_GLYPH_TABLE_LOW, {$urandom, $urandom});
         if ($urandom_range(2) == 0) write_reg(CSR_GLYPH_TABLE_HIGH, {$urandom, $urandom});

         // mostly clean frames; some noisy frame_start, some carry on mid-frame
         mode    = $urandom_range(9);
         no_gaps = ($urandom_range(3) == 0);
         for (k = 0; k < items; k++) begin
            case (mode)
               0:       fs = ($urandom_range(7) == 0);
               1:       fs = 1'b0;
               default: fs = (k % frame_len == 0);
            endcase
            case ($urandom_range(5))
               0:       px = 8'd0;
               1:       px = 8'd255;
               default: px = 8'($urandom_range(255));
            endcase
            if ($urandom_range(249) == 0) settle();
            send_pixel(px, fs, 1'b0, '0);
            sent++;
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
